// File: rtl/bounded_positional_list_defines.svh
// Assertion macros used by the list datapath (bpl_dp).
`ifndef BOUNDED_POSITIONAL_LIST_DEFINES_SVH
`define BOUNDED_POSITIONAL_LIST_DEFINES_SVH

`ifndef SYNTH
`define BPL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bounded list assertion failed");
`define BPL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("bounded list assertion failed");
`else
`define BPL_ASSERT(lbl, prop)
`define BPL_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: rtl/bpl_pkg.sv
package bpl_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 5;

  localparam logic [CNT_W-1:0] MAX_LENGTH_RESET = 5'd16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic take;
    logic ins_rd;
    logic ins_wr;
    logic ins_put;
    logic del_rd0;
    logic del_cap;
    logic del_rd;
    logic del_wr;
    logic load_out;
  } bpl_cmd_t;

  typedef struct packed {
    logic [1:0] code;
    logic       is_insert;
    logic       is_delete;
    logic       ins_more;
    logic       del_more;
    logic       out_free;
  } bpl_stat_t;

endpackage

// File: rtl/bpl_ram.sv
module bpl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bpl_dp.sv
`include "bounded_positional_list_defines.svh"

module bpl_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [bpl_pkg::CNT_W-1:0]        max_length_i,
  input  logic [1:0]                       req_type_i,
  input  logic [bpl_pkg::CNT_W-1:0]        position_i,
  input  logic signed [bpl_pkg::VAL_W-1:0] new_value_i,
  input  bpl_pkg::bpl_cmd_t                cmd_i,
  output bpl_pkg::bpl_stat_t               stat_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic signed [bpl_pkg::VAL_W-1:0] removed_value_o,
  output logic [bpl_pkg::CNT_W-1:0]        count_o,
  output logic                             full_flag_o,
  output logic                             empty_flag_o
);
  import bpl_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CAP =
    CNT_W'((DEPTH > int'(CNT_MAX)) ? int'(CNT_MAX) : DEPTH);

  logic [CNT_W-1:0]        used_q, used_d;
  logic [CNT_W-1:0]        cursor_q, cursor_d;
  logic [CNT_W-1:0]        pos_q;
  logic signed [VAL_W-1:0] val_q;
  logic [1:0]              code_q;
  logic [VAL_W-1:0]        rem_q;
  logic [CNT_W-1:0]        cap;
  logic [1:0]              eval_code;
  logic                    out_valid_q;
  logic [1:0]              out_status_q;
  logic [VAL_W-1:0]        out_removed_q;
  logic [CNT_W-1:0]        out_count_q;
  logic                    out_full_q;
  logic                    out_empty_q;
  logic                    rd_en, wr_en;
  logic [CNT_W-1:0]        rd_idx, wr_idx;
  logic [VAL_W-1:0]        wr_data, rd_data;

  assign cap = (max_length_i > DEPTH_CAP) ? DEPTH_CAP : max_length_i;

  always_comb begin
    case (req_type_i)
      REQ_INSERT: begin
        if (used_q >= cap) begin
          eval_code = ST_FULL;
        end else if (position_i > used_q) begin
          eval_code = ST_RANGE;
        end else begin
          eval_code = ST_OK;
        end
      end
      REQ_DELETE: begin
        if (used_q == '0) begin
          eval_code = ST_EMPTY;
        end else if (position_i >= used_q) begin
          eval_code = ST_RANGE;
        end else begin
          eval_code = ST_OK;
        end
      end
      REQ_CLEAR: begin
        eval_code = (used_q == '0) ? ST_EMPTY : ST_OK;
      end
      default: begin
        eval_code = ST_RANGE;
      end
    endcase
  end

  always_comb begin
    used_d   = used_q;
    cursor_d = cursor_q;
    if (cmd_i.take) begin
      cursor_d = (req_type_i == REQ_INSERT) ? used_q : position_i;
      if (eval_code == ST_OK) begin
        case (req_type_i)
          REQ_INSERT: used_d = used_q + CNT_W'(1);
          REQ_DELETE: used_d = used_q - CNT_W'(1);
          default:    used_d = '0;
        endcase
      end
    end else if (cmd_i.ins_wr) begin
      cursor_d = cursor_q - CNT_W'(1);
    end else if (cmd_i.del_wr) begin
      cursor_d = cursor_q + CNT_W'(1);
    end
  end

  assign rd_en  = cmd_i.ins_rd | cmd_i.del_rd0 | cmd_i.del_rd;
  assign rd_idx = cmd_i.ins_rd  ? cursor_q - CNT_W'(1) :
                  cmd_i.del_rd0 ? pos_q : cursor_q + CNT_W'(1);
  assign wr_en   = cmd_i.ins_wr | cmd_i.ins_put | cmd_i.del_wr;
  assign wr_idx  = cmd_i.ins_put ? pos_q : cursor_q;
  assign wr_data = cmd_i.ins_put ? val_q : rd_data;

  bpl_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(AW'(wr_idx)),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(AW'(rd_idx)),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      used_q   <= used_d;
      cursor_q <= cursor_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      pos_q  <= position_i;
      val_q  <= new_value_i;
      code_q <= eval_code;
      rem_q  <= '0;
    end else if (cmd_i.del_cap) begin
      rem_q <= rd_data;
    end
    if (cmd_i.load_out) begin
      out_status_q  <= code_q;
      out_removed_q <= rem_q;
      out_count_q   <= used_q;
      out_full_q    <= (used_q >= cap);
      out_empty_q   <= (used_q == '0);
    end
  end

  assign stat_o.code      = eval_code;
  assign stat_o.is_insert = (req_type_i == REQ_INSERT);
  assign stat_o.is_delete = (req_type_i == REQ_DELETE);
  assign stat_o.ins_more  = (cursor_q > pos_q);
  assign stat_o.del_more  = (cursor_q < used_q);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign removed_value_o = out_removed_q;
  assign count_o         = out_count_q;
  assign full_flag_o     = out_full_q;
  assign empty_flag_o    = out_empty_q;

  `BPL_ASSERT(a_load_needs_room, cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
  `BPL_ASSERT(a_refused_keeps_count, (cmd_i.take && eval_code != ST_OK) |=> $stable(used_q))
  `BPL_ASSERT(a_write_inside_list, wr_en |-> (wr_idx < used_q))
  `BPL_ASSERT(a_read_inside_list, rd_en |-> (rd_idx <= used_q))
  `BPL_ASSERT_ALWAYS(a_reset_no_result, !rst_ni |=> !out_valid_q)

endmodule

// File: rtl/bpl_ctrl.sv
module bpl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  bpl_pkg::bpl_stat_t stat_i,
  output bpl_pkg::bpl_cmd_t  cmd_o,
  output logic               in_stall_o
);
  import bpl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_RD0,
    S_DEL_CAP,
    S_DEL_RD,
    S_DEL_WR,
    S_FINISH
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (stat_i.code == ST_OK && stat_i.is_insert) begin
              state_q <= S_INS_RD;
            end else if (stat_i.code == ST_OK && stat_i.is_delete) begin
              state_q <= S_DEL_RD0;
            end else begin
              state_q <= S_FINISH;
            end
          end
        end
        S_INS_RD:  state_q <= stat_i.ins_more ? S_INS_WR : S_INS_PUT;
        S_INS_WR:  state_q <= S_INS_RD;
        S_INS_PUT: state_q <= S_FINISH;
        S_DEL_RD0: state_q <= S_DEL_CAP;
        S_DEL_CAP: state_q <= S_DEL_RD;
        S_DEL_RD:  state_q <= stat_i.del_more ? S_DEL_WR : S_FINISH;
        S_DEL_WR:  state_q <= S_DEL_RD;
        S_FINISH: begin
          if (stat_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.take     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.ins_rd   = (state_q == S_INS_RD) && stat_i.ins_more;
    cmd_o.ins_wr   = (state_q == S_INS_WR);
    cmd_o.ins_put  = (state_q == S_INS_PUT);
    cmd_o.del_rd0  = (state_q == S_DEL_RD0);
    cmd_o.del_cap  = (state_q == S_DEL_CAP);
    cmd_o.del_rd   = (state_q == S_DEL_RD) && stat_i.del_more;
    cmd_o.del_wr   = (state_q == S_DEL_WR);
    cmd_o.load_out = (state_q == S_FINISH) && stat_i.out_free;
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// File: rtl/bounded_positional_list.sv
// Bounded positional list of signed 32-bit values, head at position 0.
// Request channel: in_valid_i/in_stall_o with req_type_i, position_i and
// new_value_i; a transfer happens when valid is high and stall is low.
// Result channel: out_valid_o/out_stall_i with status, removed value, count
// and the full and empty flags; exactly one result per request, in order.
// Configuration: cfg_valid_i/cfg_ready_o writes max_length from cfg_data_i;
// ready is always high and writes are expected only while the block is idle.
// Entries live in a single-port-per-side RAM and each entry is shifted with
// one read and one write; the request channel stalls while this runs. A
// clear or refused request goes straight to its result; an insert at position
// p with n entries shifts the n-p entries from p upward, then writes the new
// value; a delete captures the entry at p and shifts the n-1-p above it down.
// A ready receiver takes the result at the edge that could take the next
// request. The result register parts the two channels, so a new request is
// taken while a result waits; a stalled receiver only holds the block once
// the next result is ready.
// Reset clears the count, drops any pending result and sets max_length to 16;
// the RAM contents are not cleared since only written entries are ever read.
module bounded_positional_list #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       req_type_i,
  input  logic [bpl_pkg::CNT_W-1:0]        position_i,
  input  logic signed [bpl_pkg::VAL_W-1:0] new_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic signed [bpl_pkg::VAL_W-1:0] removed_value_o,
  output logic [bpl_pkg::CNT_W-1:0]        count_o,
  output logic                             full_flag_o,
  output logic                             empty_flag_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bpl_pkg::CNT_W-1:0]        cfg_data_i
);
  import bpl_pkg::*;

  logic [CNT_W-1:0] max_length_q;
  bpl_cmd_t         cmd;
  bpl_stat_t        stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MAX_LENGTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_length_q <= cfg_data_i;
    end
  end

  bpl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .in_stall_o(in_stall_o)
  );

  bpl_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .max_length_i   (max_length_q),
    .req_type_i     (req_type_i),
    .position_i     (position_i),
    .new_value_i    (new_value_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .count_o        (count_o),
    .full_flag_o    (full_flag_o),
    .empty_flag_o   (empty_flag_o)
  );

endmodule

// File: tb/bounded_positional_list_tb.sv
module bounded_positional_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpl_pkg::*;

  localparam int unsigned LIST_DEPTH = 16;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 215;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] removed;
    logic [CNT_W-1:0] count;
    logic             full;
    logic             empty;
  } list_result_t;

  class list_scoreboard;
    logic [VAL_W-1:0] entries[LIST_DEPTH];
    int unsigned      used;
    logic [CNT_W-1:0] max_length;
    list_result_t     expected_q[$];
    int               errors;

    function new();
      used = 0;
      max_length = MAX_LENGTH_RESET;
      errors = 0;
    endfunction

    function int unsigned capacity();
      return (max_length > LIST_DEPTH) ? LIST_DEPTH : max_length;
    endfunction

    function void set_max_length(logic [CNT_W-1:0] value);
      max_length = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(logic [1:0] req, logic [CNT_W-1:0] pos,
                               logic [VAL_W-1:0] value);
      list_result_t r;
      int unsigned  cap;
      int           i;
      cap = capacity();
      r = '0;
      r.status = ST_OK;
      case (req)
        REQ_INSERT: begin
          if (used >= cap) begin
            r.status = ST_FULL;
          end else if (pos > used) begin
            r.status = ST_RANGE;
          end else begin
            for (i = used; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = value;
            used++;
          end
        end
        REQ_DELETE: begin
          if (used == 0) begin
            r.status = ST_EMPTY;
          end else if (pos >= used) begin
            r.status = ST_RANGE;
          end else begin
            r.removed = entries[pos];
            for (i = pos; i + 1 < used; i++) entries[i] = entries[i+1];
            used--;
          end
        end
        REQ_CLEAR: begin
          if (used == 0) r.status = ST_EMPTY;
          else used = 0;
        end
        default: begin
          r.status = ST_RANGE;
        end
      endcase
      r.count = used[CNT_W-1:0];
      r.full = (used >= cap);
      r.empty = (used == 0);
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
      $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(list_result_t got);
      list_result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result", VAL_W'(got.status), 0);
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status)
          report("status", VAL_W'(got.status), VAL_W'(want.status));
        if (got.removed !== want.removed) report("removed_value", got.removed, want.removed);
        if (got.count !== want.count)
          report("count", VAL_W'(got.count), VAL_W'(want.count));
        if (got.full !== want.full)
          report("full_flag", VAL_W'(got.full), VAL_W'(want.full));
        if (got.empty !== want.empty)
          report("empty_flag", VAL_W'(got.empty), VAL_W'(want.empty));
      end
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              req_type_i = REQ_INSERT;
  logic [CNT_W-1:0]        position_i = '0;
  logic signed [VAL_W-1:0] new_value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [1:0]              status_o;
  logic signed [VAL_W-1:0] removed_value_o;
  logic [CNT_W-1:0]        count_o;
  logic                    full_flag_o;
  logic                    empty_flag_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CNT_W-1:0]        cfg_data_i = '0;

  list_scoreboard sb = new();
  list_result_t   observed;
  int             hold_seq = 0;
  bit             stall_enable = 1'b1;

  bounded_positional_list #(
    .DEPTH(LIST_DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .position_i     (position_i),
    .new_value_i    (new_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .count_o        (count_o),
    .full_flag_o    (full_flag_o),
    .empty_flag_o   (empty_flag_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("bounded_positional_list_tb: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      observed.status = status_o;
      observed.removed = removed_value_o;
      observed.count = count_o;
      observed.full = full_flag_o;
      observed.empty = empty_flag_o;
      sb.check_result(observed);
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // The receiver stalls in runs of random length; a hold request forces one long stall.
  initial begin
    int run;
    int hold_left;
    int hold_seen;
    run = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (run > 0) begin
        run--;
      end else if (!stall_enable) begin
        out_stall_i = 1'b0;
      end else begin
        out_stall_i = ($urandom_range(0, 2) == 0);
        run = gap_len();
      end
    end
  end

  task automatic send_request(input logic [1:0] req, input logic [CNT_W-1:0] pos,
                              input logic [VAL_W-1:0] value, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    req_type_i = req;
    position_i = pos;
    new_value_i = value;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req, pos, value);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  task automatic write_max_length(input logic [CNT_W-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_max_length(value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Mostly well-formed requests aimed at live positions, with some noise.
  task automatic rand_request(input bit gaps_on);
    int               r;
    int unsigned      n;
    logic [1:0]       req;
    logic [CNT_W-1:0] pos;
    n = sb.used;
    r = $urandom_range(0, 99);
    if (r < 54) req = REQ_INSERT;
    else if (r < 94) req = REQ_DELETE;
    else if (r < 97) req = REQ_CLEAR;
    else req = REQ_UNUSED;
    if ($urandom_range(0, 9) == 0) pos = CNT_W'($urandom_range(0, 31));
    else if (req == REQ_INSERT) pos = CNT_W'($urandom_range(0, n));
    else if (n > 0) pos = CNT_W'($urandom_range(0, n - 1));
    else pos = '0;
    send_request(req, pos, rand_value(), gaps_on ? gap_len() : 0);
  endtask

  initial begin
    logic [CNT_W-1:0] caps[PHASES];
    int               burst;
    bit               gaps_on;
    caps = '{5'd5, 5'd1, 5'd0, 5'd31, 5'd10, 5'd3, 5'd0, 5'd16};
    caps[6] = CNT_W'($urandom_range(0, 31));
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(REQ_DELETE, 5'd0, 32'h0, 0);
    send_request(REQ_CLEAR, 5'd0, 32'h0, 1);
    send_request(REQ_INSERT, 5'd1, 32'h1234_5678, 0);
    send_request(REQ_INSERT, 5'd0, 32'h8000_0000, 0);
    send_request(REQ_INSERT, 5'd1, 32'h7fff_ffff, 0);
    send_request(REQ_INSERT, 5'd0, 32'hffff_ffff, 2);
    send_request(REQ_INSERT, 5'd1, 32'h0000_0000, 0);
    send_request(REQ_INSERT, 5'd31, 32'h5555_aaaa, 0);
    send_request(REQ_UNUSED, 5'd0, 32'haaaa_5555, 0);
    send_request(REQ_DELETE, 5'd4, 32'h0, 0);
    send_request(REQ_DELETE, 5'd31, 32'h0, 0);
    send_request(REQ_DELETE, 5'd0, 32'h0, 0);
    send_request(REQ_DELETE, 5'd2, 32'h0, 0);
    send_request(REQ_DELETE, 5'd0, 32'h0, 0);
    send_request(REQ_CLEAR, 5'd0, 32'h0, 0);
    send_request(REQ_UNUSED, 5'd16, 32'h0, 0);

    write_max_length(5'd2);
    send_request(REQ_INSERT, 5'd0, 32'h0000_0005, 0);
    send_request(REQ_INSERT, 5'd1, 32'h0000_0006, 0);
    send_request(REQ_INSERT, 5'd0, 32'h0000_0007, 0);
    write_max_length(5'd1);
    send_request(REQ_DELETE, 5'd0, 32'h0, 0);
    send_request(REQ_DELETE, 5'd0, 32'h0, 0);
    write_max_length(5'd0);
    send_request(REQ_INSERT, 5'd0, 32'h0000_0009, 0);
    write_max_length(MAX_LENGTH_RESET);

    burst = 0;
    for (int p = 0; p < PHASES; p++) begin
      gaps_on = (p != 2) && (p != 5);
      stall_enable = (p != 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ((p == 0 && k == 40) || (p == 3 && k == 100) || (p == 7 && k == 60)) begin
          hold_seq++;
          burst = 30;
        end
        rand_request(gaps_on && burst == 0);
        if (burst > 0) burst--;
      end
      write_max_length(caps[p]);
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("bounded_positional_list_tb: done, clean");
    end else begin
      $display("bounded_positional_list_tb: done, errors");
    end
    $finish;
  end

endmodule
